FILE: sv/cubic_bisection_root_finder_macros.svh
// assertion macros for the cubic bisection root finder checker
// expects clk and arst_n in the scope of the use
`ifndef CUBIC_BISECTION_ROOT_FINDER_MACROS_SVH
`define CUBIC_BISECTION_ROOT_FINDER_MACROS_SVH

// same-cycle implication
`define CBRF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CBRF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/cbrf_pkg.sv
// shared types and constants for the cubic bisection root finder
// no dependencies
`default_nettype none

package cbrf_pkg;

	localparam int MAX_ROUNDS_DEF = 48;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int DATA_W   = 32;
	localparam int TOL_W    = 31;
	localparam int ROUND_W  = 7;
	localparam int STATUS_W = 2;

	localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;

	localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

	localparam logic [STATUS_W-1:0] STATUS_TOL   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_LIMIT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MID,
		S_MUL1,
		S_MUL2,
		S_UPD,
		S_FIN
	} state_t;

endpackage

`default_nettype wire

FILE: sv/cubic_bisection_root_finder.sv
// bisection root finder for x^3 + 2x^2 + 10x - 20 in signed fixed point
// depends on cbrf_pkg
//
// channel   signals                                      handshake
// config    cfg_wr_en, cfg_wr_data (tolerance)           write on enable
// input     left_end, right_end                          in_valid / in_ready
// output    root_estimate, value_at_root, rounds_used,   out_valid / out_ready
//           status
//
// an item runs up to MAX_ROUNDS rounds (a bad interval runs none); each
// round walks midpoint, two passes of the one shared multiplier, and the
// bracket update
// in_ready is high only while idle; the finished result sits in an output
// register, so a new item can start while it waits
// a stalled output holds the sequencer in its final state until taken
// arst_n clears control state and sets the tolerance to its default
`default_nettype none

module cubic_bisection_root_finder #(
	parameter int MAX_ROUNDS = cbrf_pkg::MAX_ROUNDS_DEF,
	parameter int FRAC_BITS  = cbrf_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [cbrf_pkg::TOL_W-1:0]            cfg_wr_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [cbrf_pkg::DATA_W-1:0]    left_end,
	input  logic signed [cbrf_pkg::DATA_W-1:0]    right_end,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [cbrf_pkg::DATA_W-1:0]    root_estimate,
	output logic signed [cbrf_pkg::DATA_W-1:0]    value_at_root,
	output logic [cbrf_pkg::ROUND_W-1:0]          rounds_used,
	output logic [cbrf_pkg::STATUS_W-1:0]         status
);

	// beyond +-2^GUARD the cubic leaves the output range
	localparam int GUARD = (34 - FRAC_BITS) / 3;
	localparam int MW    = FRAC_BITS + GUARD + 1;
	localparam int AW    = FRAC_BITS + 2 * GUARD + 3;
	localparam int PW    = AW + MW;
	localparam int SHW   = PW - FRAC_BITS;
	localparam int SW    = SHW + 1;
	localparam int DW    = cbrf_pkg::DATA_W;
	localparam int RW    = cbrf_pkg::ROUND_W;

	localparam logic signed [DW-1:0] LIM      = 32'sd1 <<< (FRAC_BITS + GUARD);
	localparam logic signed [AW-1:0] TWO_A    = AW'(2) <<< FRAC_BITS;
	localparam logic signed [AW-1:0] TEN_A    = AW'(10) <<< FRAC_BITS;
	localparam logic signed [SW-1:0] TWENTY_S = SW'(20) <<< FRAC_BITS;
	localparam logic [RW-1:0]        LAST_RND = RW'(MAX_ROUNDS);

	cbrf_pkg::state_t state_q, state_d;

	logic [cbrf_pkg::TOL_W-1:0] tol_q;
	logic signed [DW-1:0]       low_q, high_q, mid_q, prev_q, fval_q;
	logic [DW-1:0]              v_q;
	logic [RW-1:0]              round_q;
	logic [cbrf_pkg::STATUS_W-1:0] status_q;
	logic                       guard_q;
	logic signed [MW-1:0]       m_q;
	logic signed [AW-1:0]       a_q;

	logic                          out_valid_q;
	logic signed [DW-1:0]          root_q, value_q;
	logic [RW-1:0]                 rounds_q;
	logic [cbrf_pkg::STATUS_W-1:0] stat_out_q;

	// input checks
	logic signed [DW:0] width;
	logic [DW:0]        width_p1;
	logic               bad;

	// midpoint
	logic signed [DW:0]   sum;
	logic signed [DW-1:0] mid;
	logic                 guard;

	// shared multiplier
	logic signed [PW-1:0]  mul_p;
	logic signed [SHW-1:0] mul_sh;
	logic signed [SW-1:0]  fin;
	logic                  fin_fits;
	logic signed [DW-1:0]  fin_sat;

	// round update
	logic signed [DW:0] diff;
	logic [DW:0]        diff_abs;
	logic [DW:0]        v_p1;
	logic               tol_hit, lim_hit;
	logic               fin_take;

	assign width    = {right_end[DW-1], right_end} - {left_end[DW-1], left_end};
	assign width_p1 = width + 1'b1;
	assign bad      = width[DW] || (width == '0);

	assign sum   = {low_q[DW-1], low_q} + {high_q[DW-1], high_q};
	assign mid   = sum[DW:1];
	assign guard = (mid >= LIM) || (mid <= -LIM);

	assign mul_p    = a_q * m_q;
	assign mul_sh   = mul_p[PW-1:FRAC_BITS];
	assign fin      = {mul_sh[SHW-1], mul_sh} - TWENTY_S;
	assign fin_fits = (&fin[SW-1:DW-1]) || !(|fin[SW-1:DW-1]);
	assign fin_sat  = fin_fits ? fin[DW-1:0] :
		(fin[SW-1] ? cbrf_pkg::DATA_MIN : cbrf_pkg::DATA_MAX);

	assign diff     = {mid_q[DW-1], mid_q} - {prev_q[DW-1], prev_q};
	assign diff_abs = diff[DW] ? (DW+1)'(0) - diff : diff;
	// the first round never stops on tolerance
	assign tol_hit  = (round_q != '0) && (diff_abs < {2'b00, tol_q});
	assign lim_hit  = (v_q <= {1'b0, tol_q}) || (round_q + 1'b1 == LAST_RND);
	assign v_p1     = {1'b0, v_q} + 1'b1;

	assign fin_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbrf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			cbrf_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = bad ? cbrf_pkg::S_FIN : cbrf_pkg::S_MID;
				end
			end
			cbrf_pkg::S_MID:  state_d = cbrf_pkg::S_MUL1;
			cbrf_pkg::S_MUL1: state_d = cbrf_pkg::S_MUL2;
			cbrf_pkg::S_MUL2: state_d = cbrf_pkg::S_UPD;
			cbrf_pkg::S_UPD: begin
				state_d = (tol_hit || lim_hit) ? cbrf_pkg::S_FIN : cbrf_pkg::S_MID;
			end
			cbrf_pkg::S_FIN: begin
				if (fin_take) begin
					state_d = cbrf_pkg::S_IDLE;
				end
			end
			default: state_d = cbrf_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= cbrf_pkg::TOL_RESET;
		end else if (cfg_wr_en) begin
			tol_q <= cfg_wr_data;
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			cbrf_pkg::S_IDLE: begin
				if (in_valid) begin
					low_q   <= left_end;
					high_q  <= right_end;
					prev_q  <= '0;
					round_q <= '0;
					v_q     <= width_p1[DW:1];
					mid_q   <= '0;
					fval_q  <= '0;
					status_q <= cbrf_pkg::STATUS_BAD;
				end
			end
			cbrf_pkg::S_MID: begin
				mid_q   <= mid;
				guard_q <= guard;
				m_q     <= mid[MW-1:0];
				a_q     <= {{(AW-MW){mid[MW-1]}}, mid[MW-1:0]} + TWO_A;
			end
			cbrf_pkg::S_MUL1: begin
				a_q <= mul_sh[AW-1:0] + TEN_A;
			end
			cbrf_pkg::S_MUL2: begin
				if (guard_q) begin
					fval_q <= mid_q[DW-1] ? cbrf_pkg::DATA_MIN : cbrf_pkg::DATA_MAX;
				end else begin
					fval_q <= fin_sat;
				end
			end
			cbrf_pkg::S_UPD: begin
				// a zero of the cubic leaves the bracket alone
				if (!fval_q[DW-1] && (fval_q != '0)) begin
					high_q <= mid_q;
				end else if (fval_q[DW-1]) begin
					low_q <= mid_q;
				end
				prev_q  <= mid_q;
				round_q <= round_q + 1'b1;
				v_q     <= v_p1[DW:1];
				status_q <= tol_hit ? cbrf_pkg::STATUS_TOL : cbrf_pkg::STATUS_LIMIT;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == cbrf_pkg::S_FIN && fin_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cbrf_pkg::S_FIN && fin_take) begin
			root_q     <= mid_q;
			value_q    <= fval_q;
			rounds_q   <= round_q;
			stat_out_q <= status_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign root_estimate = root_q;
	assign value_at_root = value_q;
	assign rounds_used   = rounds_q;
	assign status        = stat_out_q;

endmodule

`default_nettype wire

FILE: sv/cbrf_checker.sv
// port-level checks for the cubic bisection root finder, bound to the top level
// depends on cbrf_pkg and cubic_bisection_root_finder_macros.svh
`default_nettype none

`include "cubic_bisection_root_finder_macros.svh"

module cbrf_checker #(
	parameter int MAX_ROUNDS = cbrf_pkg::MAX_ROUNDS_DEF
) (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               cfg_wr_en,
	input wire logic [cbrf_pkg::TOL_W-1:0]         cfg_wr_data,
	input wire logic                               in_valid,
	input wire logic                               in_ready,
	input wire logic signed [cbrf_pkg::DATA_W-1:0] left_end,
	input wire logic signed [cbrf_pkg::DATA_W-1:0] right_end,
	input wire logic                               out_valid,
	input wire logic                               out_ready,
	input wire logic signed [cbrf_pkg::DATA_W-1:0] root_estimate,
	input wire logic signed [cbrf_pkg::DATA_W-1:0] value_at_root,
	input wire logic [cbrf_pkg::ROUND_W-1:0]       rounds_used,
	input wire logic [cbrf_pkg::STATUS_W-1:0]      status
);

	localparam logic [cbrf_pkg::ROUND_W-1:0] LAST_RND = cbrf_pkg::ROUND_W'(MAX_ROUNDS);

	// a bad interval reports nothing but its status
	`CBRF_ASSERT_NOW(a_bad_clean, out_valid && status == cbrf_pkg::STATUS_BAD, rounds_used == '0 && root_estimate == '0 && value_at_root == '0, "bad interval item carries data")

	// every real run does at least one round and never exceeds the cap
	`CBRF_ASSERT_NOW(a_round_range, out_valid && status != cbrf_pkg::STATUS_BAD, rounds_used != '0 && rounds_used <= LAST_RND, "round count out of range")

	// the first round never stops on tolerance
	`CBRF_ASSERT_NOW(a_tol_two, out_valid && status == cbrf_pkg::STATUS_TOL, rounds_used >= 2, "tolerance stop before second round")

	// busy right after taking an item
	`CBRF_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "ready right after accept")

	// a stalled result holds
	`CBRF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(root_estimate) && $stable(status), "stalled item changed")

endmodule

bind cubic_bisection_root_finder cbrf_checker #(.MAX_ROUNDS(MAX_ROUNDS)) u_cbrf_checker (.*);

`default_nettype wire

FILE: test/tb_cubic_bisection_root_finder.sv
// self-checking testbench for cubic_bisection_root_finder: a directed table, then random
// brackets under several tolerance settings, each result checked against its table row or a local model
// depends on cbrf_pkg and the block under test
`default_nettype none

module tb_cubic_bisection_root_finder;

	localparam int GUARD_EXP = (34 - cbrf_pkg::FRAC_BITS_DEF) / 3;
	localparam longint ROOT_NEAR = 89706;	// f crosses zero near 1.3688
	localparam int PHASE_ITEMS = 130;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PRESSURE_AT = 60;
	localparam int PRESSURE_LEN = 1500;

	typedef struct {
		logic signed [cbrf_pkg::DATA_W-1:0] root;
		logic signed [cbrf_pkg::DATA_W-1:0] fval;
		logic [cbrf_pkg::ROUND_W-1:0] rounds;
		logic [cbrf_pkg::STATUS_W-1:0] stat;
	} root_result_t;

	typedef struct {
		bit typed;
		logic [cbrf_pkg::TOL_W-1:0] tol;
		logic signed [cbrf_pkg::DATA_W-1:0] l;
		logic signed [cbrf_pkg::DATA_W-1:0] r;
		root_result_t want;
	} bracket_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [cbrf_pkg::TOL_W-1:0] cfg_wr_data;
	logic in_valid;
	logic in_ready;
	logic signed [cbrf_pkg::DATA_W-1:0] left_end;
	logic signed [cbrf_pkg::DATA_W-1:0] right_end;
	logic out_valid;
	logic out_ready;
	logic signed [cbrf_pkg::DATA_W-1:0] root_estimate;
	logic signed [cbrf_pkg::DATA_W-1:0] value_at_root;
	logic [cbrf_pkg::ROUND_W-1:0] rounds_used;
	logic [cbrf_pkg::STATUS_W-1:0] status;

	root_result_t pending_roots[$];
	root_result_t oldest;
	bracket_row_t bracket_rows[$];
	logic [cbrf_pkg::TOL_W-1:0] cur_tol;
	logic [cbrf_pkg::TOL_W-1:0] tol_set[6];
	int mismatches;
	int results_taken;
	int items_sent;
	int tol_writes;
	int n_stop_tol;
	int n_stop_limit;
	int n_bad;
	int cycle_count;
	int hold_left;
	int calm_left;
	bit pressure_done;

	cubic_bisection_root_finder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.left_end      (left_end),
		.right_end     (right_end),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.root_estimate (root_estimate),
		.value_at_root (value_at_root),
		.rounds_used   (rounds_used),
		.status        (status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// f(x) = ((x + 2) * x + 10) * x - 20, products floored back to the fraction width
	function automatic longint cubic_q16(longint m);
		longint one;
		longint lim;
		longint t;
		one = longint'(1) << cbrf_pkg::FRAC_BITS_DEF;
		lim = longint'(1) << (cbrf_pkg::FRAC_BITS_DEF + GUARD_EXP);
		if (m >= lim)
			return longint'(cbrf_pkg::DATA_MAX);
		if (m <= -lim)
			return longint'(cbrf_pkg::DATA_MIN);
		t = m + 2 * one;
		t = ((t * m) >>> cbrf_pkg::FRAC_BITS_DEF) + 10 * one;
		t = ((t * m) >>> cbrf_pkg::FRAC_BITS_DEF) - 20 * one;
		if (t > longint'(cbrf_pkg::DATA_MAX))
			t = longint'(cbrf_pkg::DATA_MAX);
		if (t < longint'(cbrf_pkg::DATA_MIN))
			t = longint'(cbrf_pkg::DATA_MIN);
		return t;
	endfunction

	function automatic root_result_t solve_bracket(logic signed [cbrf_pkg::DATA_W-1:0] l,
			logic signed [cbrf_pkg::DATA_W-1:0] r, logic [cbrf_pkg::TOL_W-1:0] tol);
		root_result_t res;
		longint lo;
		longint hi;
		longint width;
		longint v;
		longint mid;
		longint prev;
		longint diff;
		longint f;
		longint tol_l;
		int limit;
		int rounds;
		lo = l;
		hi = r;
		tol_l = longint'(tol);
		width = hi - lo;
		res.root = '0;
		res.fval = '0;
		res.rounds = '0;
		res.stat = cbrf_pkg::STATUS_BAD;
		if (width <= 0)
			return res;
		// round limit: smallest k with width / 2^k, rounded up, within tolerance, at most MAX_ROUNDS_DEF
		v = (width + 1) / 2;
		limit = 1;
		while (v > tol_l && limit < cbrf_pkg::MAX_ROUNDS_DEF) begin
			v = (v + 1) / 2;
			limit++;
		end
		res.stat = cbrf_pkg::STATUS_LIMIT;
		prev = 0;
		rounds = 0;
		mid = 0;
		f = 0;
		while (rounds < limit) begin
			mid = (lo + hi) >>> 1;
			f = cubic_q16(mid);
			diff = (mid > prev) ? mid - prev : prev - mid;
			if (f > 0)
				hi = mid;
			else if (f < 0)
				lo = mid;
			prev = mid;
			rounds++;
			if (rounds > 1 && diff < tol_l) begin
				res.stat = cbrf_pkg::STATUS_TOL;
				break;
			end
		end
		res.root = mid[cbrf_pkg::DATA_W-1:0];
		res.fval = f[cbrf_pkg::DATA_W-1:0];
		res.rounds = rounds[cbrf_pkg::ROUND_W-1:0];
		return res;
	endfunction

	function automatic void add_row(bit typed, logic [cbrf_pkg::TOL_W-1:0] tol,
			logic signed [cbrf_pkg::DATA_W-1:0] l, logic signed [cbrf_pkg::DATA_W-1:0] r,
			logic signed [cbrf_pkg::DATA_W-1:0] root,
			logic signed [cbrf_pkg::DATA_W-1:0] fval,
			int rounds, logic [cbrf_pkg::STATUS_W-1:0] stat);
		bracket_row_t row;
		row.typed = typed;
		row.tol = tol;
		row.l = l;
		row.r = r;
		row.want.root = root;
		row.want.fval = fval;
		row.want.rounds = rounds[cbrf_pkg::ROUND_W-1:0];
		row.want.stat = stat;
		bracket_rows.push_back(row);
	endfunction

	function automatic void gen_bracket(output logic signed [cbrf_pkg::DATA_W-1:0] l,
			output logic signed [cbrf_pkg::DATA_W-1:0] r);
		longint a;
		longint b;
		longint span;
		longint center;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			// empty or reversed bracket
			a = longint'($signed($urandom));
			b = a - longint'($urandom_range(0, 1000));
		end else if (sel < 25) begin
			a = longint'($signed($urandom));
			b = longint'($signed($urandom));
		end else begin
			span = longint'(1) << $urandom_range(0, 30);
			center = ROOT_NEAR;
			if ($urandom_range(0, 4) == 0)
				center += longint'($signed($urandom));
			a = center - longint'($urandom_range(0, int'(span)));
			b = center + 1 + longint'($urandom_range(0, int'(span)));
		end
		if (a > longint'(cbrf_pkg::DATA_MAX)) a = cbrf_pkg::DATA_MAX;
		if (a < longint'(cbrf_pkg::DATA_MIN)) a = cbrf_pkg::DATA_MIN;
		if (b > longint'(cbrf_pkg::DATA_MAX)) b = cbrf_pkg::DATA_MAX;
		if (b < longint'(cbrf_pkg::DATA_MIN)) b = cbrf_pkg::DATA_MIN;
		l = a[cbrf_pkg::DATA_W-1:0];
		r = b[cbrf_pkg::DATA_W-1:0];
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		$display("mismatch at result %0d: %s got %0d expected %0d",
			results_taken, what, got, want);
	endtask

	// called at a falling edge; returns at a falling edge after the gap
	task automatic push_item(logic signed [cbrf_pkg::DATA_W-1:0] l,
			logic signed [cbrf_pkg::DATA_W-1:0] r,
			bit typed, root_result_t typed_want);
		int sel;
		int gap;
		left_end = l;
		right_end = r;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_roots.push_back(typed ? typed_want : solve_bracket(l, r, cur_tol));
		items_sent++;
		@(negedge clk);
		sel = $urandom_range(0, 99);
		if (sel < 60) gap = 0;
		else if (sel < 90) gap = $urandom_range(1, 3);
		else if (sel < 97) gap = $urandom_range(4, 10);
		else gap = $urandom_range(20, 60);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// only written with the block idle and every result back
	task automatic write_tolerance(logic [cbrf_pkg::TOL_W-1:0] tol);
		in_valid = 1'b0;
		while (pending_roots.size() != 0) @(posedge clk);
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = tol;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cur_tol = tol;
		tol_writes++;
	endtask

	// receiver: random stalls, calm stretches, and one long hold-off
	always @(negedge clk) begin
		int sel;
		if (!pressure_done && results_taken >= PRESSURE_AT) begin
			pressure_done = 1'b1;
			hold_left = PRESSURE_LEN;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (calm_left > 0) begin
			out_ready <= 1'b1;
			calm_left--;
		end else begin
			sel = $urandom_range(0, 99);
			if (sel < 50) begin
				out_ready <= 1'b1;
			end else if (sel < 85) begin
				out_ready <= 1'b0;
				hold_left = $urandom_range(0, 3);
			end else if (sel < 95) begin
				out_ready <= 1'b1;
				calm_left = $urandom_range(20, 200);
			end else begin
				out_ready <= 1'b0;
				hold_left = $urandom_range(10, 60);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_roots.size() == 0) begin
				report_mismatch("result with nothing pending, root_estimate",
					root_estimate, 0);
			end else begin
				oldest = pending_roots.pop_front();
				if (root_estimate !== oldest.root)
					report_mismatch("root_estimate", root_estimate, oldest.root);
				if (value_at_root !== oldest.fval)
					report_mismatch("value_at_root", value_at_root, oldest.fval);
				if (rounds_used !== oldest.rounds)
					report_mismatch("rounds_used", rounds_used, oldest.rounds);
				if (status !== oldest.stat)
					report_mismatch("status", status, oldest.stat);
				case (oldest.stat)
					cbrf_pkg::STATUS_TOL:   n_stop_tol++;
					cbrf_pkg::STATUS_LIMIT: n_stop_limit++;
					default:                n_bad++;
				endcase
			end
			results_taken++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_roots.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic signed [cbrf_pkg::DATA_W-1:0] l;
		logic signed [cbrf_pkg::DATA_W-1:0] r;
		longint zero_at;
		root_result_t none;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		left_end = '0;
		right_end = '0;
		out_ready = 1'b0;
		cur_tol = cbrf_pkg::TOL_RESET;
		none = solve_bracket(0, 0, cbrf_pkg::TOL_RESET);

		// look for an exact fixed-point zero of f; else take the first point past it
		zero_at = 0;
		for (longint m = 89000; m <= 90500 && zero_at == 0; m++)
			if (cubic_q16(m) >= 0)
				zero_at = m;

		// bad brackets, extremes and narrow brackets first, under the reset tolerance
		add_row(1, cbrf_pkg::TOL_RESET, 0, 0, 0, 0, 0, cbrf_pkg::STATUS_BAD);
		add_row(1, cbrf_pkg::TOL_RESET, cbrf_pkg::DATA_MAX, cbrf_pkg::DATA_MIN, 0, 0, 0,
			cbrf_pkg::STATUS_BAD);
		add_row(1, cbrf_pkg::TOL_RESET, cbrf_pkg::DATA_MIN, cbrf_pkg::DATA_MIN, 0, 0, 0,
			cbrf_pkg::STATUS_BAD);
		add_row(1, cbrf_pkg::TOL_RESET, 5 <<< 16, -(3 <<< 16), 0, 0, 0,
			cbrf_pkg::STATUS_BAD);
		add_row(1, cbrf_pkg::TOL_RESET, 0, 1, 0, -(20 <<< 16), 1, cbrf_pkg::STATUS_LIMIT);
		add_row(1, cbrf_pkg::TOL_RESET, cbrf_pkg::DATA_MAX - 1, cbrf_pkg::DATA_MAX,
			cbrf_pkg::DATA_MAX - 1, cbrf_pkg::DATA_MAX, 1, cbrf_pkg::STATUS_LIMIT);
		add_row(1, cbrf_pkg::TOL_RESET, cbrf_pkg::DATA_MIN, cbrf_pkg::DATA_MIN + 1,
			cbrf_pkg::DATA_MIN, cbrf_pkg::DATA_MIN, 1, cbrf_pkg::STATUS_LIMIT);
		add_row(0, cbrf_pkg::TOL_RESET, cbrf_pkg::DATA_MIN, cbrf_pkg::DATA_MAX, 0, 0, 0,
			cbrf_pkg::STATUS_TOL);
		add_row(0, cbrf_pkg::TOL_RESET, 0, 2 <<< 16, 0, 0, 0, cbrf_pkg::STATUS_TOL);
		add_row(0, cbrf_pkg::TOL_RESET, -(8 <<< 16), 8 <<< 16, 0, 0, 0,
			cbrf_pkg::STATUS_TOL);
		add_row(0, cbrf_pkg::TOL_RESET, cbrf_pkg::DATA_W'(zero_at - 1000),
			cbrf_pkg::DATA_W'(zero_at + 1000), 0, 0, 0, cbrf_pkg::STATUS_TOL);
		add_row(0, cbrf_pkg::TOL_RESET, 1 <<< 16, 2 <<< 16, 0, 0, 0, cbrf_pkg::STATUS_TOL);
		add_row(0, cbrf_pkg::TOL_RESET, 32'shAAAA_AAAA, 32'sh5555_5555, 0, 0, 0,
			cbrf_pkg::STATUS_TOL);
		// zero tolerance runs to the full round count
		add_row(0, '0, 0, 2 <<< 16, 0, 0, 0, cbrf_pkg::STATUS_TOL);
		add_row(0, '0, cbrf_pkg::DATA_MIN, cbrf_pkg::DATA_MAX, 0, 0, 0,
			cbrf_pkg::STATUS_TOL);
		add_row(1, '0, 3, 3, 0, 0, 0, cbrf_pkg::STATUS_BAD);
		// widest tolerance: a single round where half the width fits, saturated f at both ends
		add_row(1, 31'h7FFF_FFFF, 32'sh4000_0000, cbrf_pkg::DATA_MAX, 32'sh5FFF_FFFF,
			cbrf_pkg::DATA_MAX, 1, cbrf_pkg::STATUS_LIMIT);
		add_row(1, 31'h7FFF_FFFF, cbrf_pkg::DATA_MIN, 32'shC000_0000, 32'shA000_0000,
			cbrf_pkg::DATA_MIN, 1, cbrf_pkg::STATUS_LIMIT);
		add_row(0, 31'h7FFF_FFFF, cbrf_pkg::DATA_MIN, cbrf_pkg::DATA_MAX, 0, 0, 0,
			cbrf_pkg::STATUS_TOL);
		add_row(0, 31'd1, -(4 <<< 16), 4 <<< 16, 0, 0, 0, cbrf_pkg::STATUS_TOL);
		add_row(0, 31'd1, cbrf_pkg::DATA_W'(zero_at - 3), cbrf_pkg::DATA_W'(zero_at + 5),
			0, 0, 0, cbrf_pkg::STATUS_TOL);

		tol_set[0] = 31'd1;
		tol_set[1] = 31'h7FFF_FFFF;
		tol_set[2] = '0;
		tol_set[3] = cbrf_pkg::TOL_RESET;
		tol_set[4] = cbrf_pkg::TOL_W'($urandom_range(2, 65536));
		tol_set[5] = cbrf_pkg::TOL_W'($urandom);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (bracket_rows[i]) begin
			if (bracket_rows[i].tol !== cur_tol)
				write_tolerance(bracket_rows[i].tol);
			push_item(bracket_rows[i].l, bracket_rows[i].r, bracket_rows[i].typed,
				bracket_rows[i].want);
		end

		foreach (tol_set[p]) begin
			write_tolerance(tol_set[p]);
			repeat (PHASE_ITEMS) begin
				gen_bracket(l, r);
				push_item(l, r, 1'b0, none);
			end
		end

		in_valid = 1'b0;
		while (pending_roots.size() != 0) @(posedge clk);
		repeat (4 * cbrf_pkg::MAX_ROUNDS_DEF + 8) @(posedge clk);

		$display("covered %0d brackets under %0d tolerance writes plus the reset value",
			items_sent, tol_writes);
		$display("results: %0d stopped on tolerance, %0d at round limit, %0d bad brackets",
			n_stop_tol, n_stop_limit, n_bad);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
